/* hw/rtl/ftcpd_pkg.sv */
// ----------------------------------------------------------------------------
// ftcpd_pkg
// Shared types and codes for the thresholded closest-point fiber distance.
// ----------------------------------------------------------------------------
`default_nettype none

package ftcpd_pkg;

	localparam int FIELD_W = 16;
	localparam int THR_W   = 34;
	localparam int OUT_W   = 17;

	typedef struct packed {
		logic                      req_type;
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] pos_z;
		logic                      last;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] short_distance;
		logic [OUT_W-1:0] long_distance;
		logic [1:0]       status;
	} result_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_DROP  = 2'd2;

	// tag riding along the square-root chain
	typedef struct packed {
		logic valid;
		logic side;
	} sqrt_tag_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_SQ,
		ST_ACC,
		ST_COL_RD,
		ST_COL_CHK,
		ST_DRAIN,
		ST_DIV
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/ftcpd_ram.sv */
// ----------------------------------------------------------------------------
// ftcpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcpd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/ftcpd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// ftcpd_sqrt_cell
// One digit of a pipelined integer square root: two radicand bits per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcpd_sqrt_cell #(
	parameter int SW = 17
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ftcpd_pkg::sqrt_tag_t  in_tag,
	input  wire logic [SW:0]           in_rem,
	input  wire logic [SW-1:0]         in_root,
	input  wire logic [2*SW-1:0]       in_rad,
	output ftcpd_pkg::sqrt_tag_t       out_tag,
	output logic      [SW:0]           out_rem,
	output logic      [SW-1:0]         out_root,
	output logic      [2*SW-1:0]       out_rad
);
	logic [SW+2:0] cand;
	logic [SW+2:0] trial;
	logic          take;

	assign cand  = {in_rem, in_rad[2*SW-1 -: 2]};
	assign trial = (SW+3)'({in_root, 2'b01});
	assign take  = cand >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tag <= '0;
		end else begin
			out_tag <= in_tag;
		end
	end

	always_ff @(posedge clk) begin
		out_rem  <= take ? (SW+1)'(cand - trial) : cand[SW:0];
		out_root <= {in_root[SW-2:0], take};
		out_rad  <= {in_rad[2*SW-3:0], 2'b00};
	end

endmodule

`default_nettype wire

/* hw/rtl/fiber_thresholded_closest_point_distance.sv */
// ----------------------------------------------------------------------------
// fiber_thresholded_closest_point_distance
// Mean thresholded closest-point distance between two 3D polylines.
// ----------------------------------------------------------------------------
// Usage:
//  - Points come in on req; a transfer happens when start is high and busy low.
//    Send first-fiber points (req_type 0), then second-fiber points
//    (req_type 1); last on the final second-fiber point starts the compute.
//  - Loading takes one point per cycle, busy stays low.
//  - Compute: each point pair goes through point RAM read, square, and sum
//    and min update; then the column minima are swept, the square-root cell
//    chain is drained, and a serial divider forms both means. busy is high
//    the whole time.
//  - done strobes one cycle with result. An empty first fiber answers in the
//    cycle after the last transfer, status EMPTY, both distances zero.
//  - The receiver cannot stall; results are one-cycle strobes.
//  - threshold_square is written over cfg_valid/cfg_data (cfg_ready always
//    high); write it only while idle, the block does not enforce this.
//  - Reset clears counts, drop flag, threshold and control; point RAMs are
//    left as they are and never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module fiber_thresholded_closest_point_distance #(
	parameter int MAX_POINTS  = 256,
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire ftcpd_pkg::req_t               req,
	output logic                               done,
	output ftcpd_pkg::result_t                 result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ftcpd_pkg::THR_W-1:0]   cfg_data
);
	localparam int CW   = COORD_WIDTH;
	localparam int SW   = CW + 1;            // root width
	localparam int DW   = 2 * SW;            // squared distance width
	localparam int PW   = 3 * CW;            // stored point
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SUMW = SW + CNTW;
	localparam int CMPW = (DW > ftcpd_pkg::THR_W) ? DW : ftcpd_pkg::THR_W;
	localparam int BW   = $clog2(SUMW);
	localparam int DRW  = $clog2(SW + 1);

	// squared difference of one axis
	function automatic logic [2*CW-1:0] sqd(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic signed [CW:0] df;
		logic [CW-1:0]      m;
		df  = signed'({a[CW-1], a}) - signed'({b[CW-1], b});
		m   = df[CW] ? CW'(-df) : df[CW-1:0];
		sqd = (2*CW)'(m) * (2*CW)'(m);
	endfunction

	ftcpd_pkg::state_t state_q, state_d;

	logic [ftcpd_pkg::THR_W-1:0] thr_q;
	logic [CNTW-1:0] n1_q, n2_q, i_q, j_q;
	logic            ovf_q;
	logic [2*CW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic [DW-1:0]   cm_s1, rowmin_q;
	logic [SUMW-1:0] sum1_q, sum2_q, quo_q, mean1_q;
	logic [CNTW-1:0] rem_q, div_q;
	logic [BW-1:0]   bit_q;
	logic            sel_q;
	logic [DRW-1:0]  drain_q;

	// load side
	logic accept, full1, full2, we1, we2, empty_hit, go;
	logic [PW-1:0] pt_w;

	assign busy      = state_q != ftcpd_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign full1     = n1_q == CNTW'(MAX_POINTS);
	assign full2     = n2_q == CNTW'(MAX_POINTS);
	assign we1       = accept && !req.req_type && !full1;
	assign we2       = accept && req.req_type && !full2;
	assign empty_hit = accept && req.req_type && req.last && (n1_q == '0);
	assign go        = accept && req.req_type && req.last && (n1_q != '0);
	assign pt_w      = {CW'($unsigned(req.pos_x)), CW'($unsigned(req.pos_y)),
	                    CW'($unsigned(req.pos_z))};

	// memories
	logic [PW-1:0] p1_rd, p2_rd;
	logic [DW-1:0] cm_rd, d_sum, rm_new;
	logic          cm_we, last_j;

	ftcpd_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_first (
		.clk(clk), .we(we1), .waddr(n1_q[AW-1:0]), .wdata(pt_w),
		.raddr(i_q[AW-1:0]), .rdata(p1_rd)
	);
	ftcpd_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_second (
		.clk(clk), .we(we2), .waddr(n2_q[AW-1:0]), .wdata(pt_w),
		.raddr(j_q[AW-1:0]), .rdata(p2_rd)
	);

	assign d_sum  = DW'(sqx_s1) + DW'(sqy_s1) + DW'(sqz_s1);
	// first row initializes every column minimum
	assign cm_we  = (state_q == ftcpd_pkg::ST_ACC) && ((i_q == '0) || (d_sum < cm_s1));
	assign rm_new = ((j_q == '0) || (d_sum < rowmin_q)) ? d_sum : rowmin_q;
	assign last_j = j_q == (n2_q - CNTW'(1));

	ftcpd_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_colmin (
		.clk(clk), .we(cm_we), .waddr(j_q[AW-1:0]), .wdata(d_sum),
		.raddr(j_q[AW-1:0]), .rdata(cm_rd)
	);

	// square-root chain feed: row minima, then column minima
	ftcpd_pkg::sqrt_tag_t tag_c  [SW+1];
	logic [SW:0]          rem_c  [SW+1];
	logic [SW-1:0]        root_c [SW+1];
	logic [2*SW-1:0]      rad_c  [SW+1];
	logic [DW-1:0]        feed_v;
	ftcpd_pkg::sqrt_tag_t feed_tag;

	always_comb begin
		feed_tag = '0;
		feed_v   = rm_new;
		if (state_q == ftcpd_pkg::ST_ACC && last_j) begin
			feed_tag.valid = CMPW'(rm_new) > CMPW'(thr_q);
			feed_tag.side  = 1'b0;
		end else if (state_q == ftcpd_pkg::ST_COL_CHK) begin
			feed_v         = cm_rd;
			feed_tag.valid = CMPW'(cm_rd) > CMPW'(thr_q);
			feed_tag.side  = 1'b1;
		end
	end

	assign tag_c[0]  = feed_tag;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign rad_c[0]  = feed_v;

	for (genvar k = 0; k < SW; k++) begin : g_cell
		ftcpd_sqrt_cell #(.SW(SW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_tag(tag_c[k]), .in_rem(rem_c[k]), .in_root(root_c[k]), .in_rad(rad_c[k]),
			.out_tag(tag_c[k+1]), .out_rem(rem_c[k+1]), .out_root(root_c[k+1]),
			.out_rad(rad_c[k+1])
		);
	end

	// serial restoring divider step
	logic [CNTW:0]   dv_t;
	logic            dv_take;
	logic [SUMW-1:0] quo_n;
	logic            div_end;

	assign dv_t    = {rem_q, quo_q[SUMW-1]};
	assign dv_take = dv_t >= {1'b0, div_q};
	assign quo_n   = {quo_q[SUMW-2:0], dv_take};
	assign div_end = bit_q == BW'(SUMW - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ftcpd_pkg::ST_IDLE:    if (go) state_d = ftcpd_pkg::ST_RD;
			ftcpd_pkg::ST_RD:      state_d = ftcpd_pkg::ST_SQ;
			ftcpd_pkg::ST_SQ:      state_d = ftcpd_pkg::ST_ACC;
			ftcpd_pkg::ST_ACC: begin
				if (last_j && (i_q == (n1_q - CNTW'(1)))) state_d = ftcpd_pkg::ST_COL_RD;
				else state_d = ftcpd_pkg::ST_RD;
			end
			ftcpd_pkg::ST_COL_RD:  state_d = ftcpd_pkg::ST_COL_CHK;
			ftcpd_pkg::ST_COL_CHK: state_d = last_j ? ftcpd_pkg::ST_DRAIN : ftcpd_pkg::ST_COL_RD;
			ftcpd_pkg::ST_DRAIN:   if (drain_q == DRW'(SW)) state_d = ftcpd_pkg::ST_DIV;
			ftcpd_pkg::ST_DIV:     if (div_end && sel_q) state_d = ftcpd_pkg::ST_IDLE;
			default:               state_d = ftcpd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftcpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result strobe: empty answer or end of the second division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= empty_hit || (state_q == ftcpd_pkg::ST_DIV && div_end && sel_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			n1_q    <= '0;
			n2_q    <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			drain_q <= '0;
			bit_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) thr_q <= cfg_data;
			case (state_q)
				ftcpd_pkg::ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					if (empty_hit) begin
						n1_q  <= '0;
						n2_q  <= '0;
						ovf_q <= 1'b0;
					end else begin
						if (we1) n1_q <= n1_q + CNTW'(1);
						if (we2) n2_q <= n2_q + CNTW'(1);
						if (accept && !we1 && !we2) ovf_q <= 1'b1;
					end
				end
				ftcpd_pkg::ST_ACC: begin
					if (last_j) begin
						j_q <= '0;
						if (i_q != (n1_q - CNTW'(1))) i_q <= i_q + CNTW'(1);
					end else begin
						j_q <= j_q + CNTW'(1);
					end
				end
				ftcpd_pkg::ST_COL_CHK: begin
					j_q     <= j_q + CNTW'(1);
					drain_q <= '0;
				end
				ftcpd_pkg::ST_DRAIN: begin
					drain_q <= drain_q + DRW'(1);
					bit_q   <= '0;
					sel_q   <= 1'b0;
				end
				ftcpd_pkg::ST_DIV: begin
					bit_q <= div_end ? '0 : bit_q + BW'(1);
					if (div_end) begin
						sel_q <= 1'b1;
						if (sel_q) begin
							n1_q  <= '0;
							n2_q  <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	logic [SUMW-1:0] lo_v, hi_v;
	assign lo_v = (mean1_q < quo_n) ? mean1_q : quo_n;
	assign hi_v = (mean1_q < quo_n) ? quo_n : mean1_q;

	always_ff @(posedge clk) begin
		if (state_q == ftcpd_pkg::ST_SQ) begin
			sqx_s1 <= sqd(p1_rd[PW-1 -: CW], p2_rd[PW-1 -: CW]);
			sqy_s1 <= sqd(p1_rd[2*CW-1 -: CW], p2_rd[2*CW-1 -: CW]);
			sqz_s1 <= sqd(p1_rd[CW-1:0], p2_rd[CW-1:0]);
			cm_s1  <= cm_rd;
		end
		if (state_q == ftcpd_pkg::ST_ACC) rowmin_q <= rm_new;

		if (go) begin
			sum1_q <= '0;
			sum2_q <= '0;
		end else if (tag_c[SW].valid) begin
			if (tag_c[SW].side) sum2_q <= sum2_q + SUMW'(root_c[SW]);
			else                sum1_q <= sum1_q + SUMW'(root_c[SW]);
		end

		if (state_q == ftcpd_pkg::ST_DRAIN) begin
			quo_q <= sum1_q;
			rem_q <= '0;
			div_q <= n1_q;
		end else if (state_q == ftcpd_pkg::ST_DIV) begin
			if (div_end && !sel_q) begin
				mean1_q <= quo_n;
				quo_q   <= sum2_q;
				rem_q   <= '0;
				div_q   <= n2_q;
			end else begin
				quo_q <= quo_n;
				rem_q <= dv_take ? CNTW'(dv_t - {1'b0, div_q}) : dv_t[CNTW-1:0];
			end
		end

		if (empty_hit) begin
			result.short_distance <= '0;
			result.long_distance  <= '0;
			result.status         <= ftcpd_pkg::STATUS_EMPTY;
		end else if (state_q == ftcpd_pkg::ST_DIV && div_end && sel_q) begin
			result.short_distance <= ftcpd_pkg::OUT_W'(lo_v);
			result.long_distance  <= ftcpd_pkg::OUT_W'(hi_v);
			result.status         <= ovf_q ? ftcpd_pkg::STATUS_DROP : ftcpd_pkg::STATUS_OK;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ftcpd_checker.sv */
// ----------------------------------------------------------------------------
// ftcpd_props
// Port-level checks on the fiber distance block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcpd_props (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire ftcpd_pkg::req_t    req,
	input wire logic               done,
	input wire ftcpd_pkg::result_t result
);
	// a first-fiber point never produces a result
	a_no_result_first: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !req.req_type) |=> !done)
		else $error("result after first-fiber point");

	// compute only starts on a last second-fiber point
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req.req_type && req.last))
		else $error("busy without last point");

	// ordering of the two means
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.short_distance <= result.long_distance))
		else $error("short above long");

	// empty fiber gives zero distances
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ftcpd_pkg::STATUS_EMPTY) |->
		(result.short_distance == '0 && result.long_distance == '0))
		else $error("empty status with distance");

	// legal status codes only
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ftcpd_pkg::STATUS_OK ||
		          result.status == ftcpd_pkg::STATUS_EMPTY ||
		          result.status == ftcpd_pkg::STATUS_DROP))
		else $error("bad status code");

endmodule

bind fiber_thresholded_closest_point_distance ftcpd_props u_ftcpd_props (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
	.done(done), .result(result)
);

`default_nettype wire
